// ===== design/crcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, byte codes, result kinds and the CRC16 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfr_pkg;

  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] ACK_BYTE = 8'h06;

  localparam logic [2:0] KIND_ACK       = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD   = 3'd1;
  localparam logic [2:0] KIND_RESP_DONE = 3'd2;
  localparam logic [2:0] KIND_EVT_DONE  = 3'd3;
  localparam logic [2:0] KIND_CRC_ERR   = 3'd4;
  localparam logic [2:0] KIND_LEN_ERR   = 3'd5;

  localparam logic [1:0] REG_CRC_POLY     = 2'd0;
  localparam logic [1:0] REG_EVT_ENTRY    = 2'd1;
  localparam logic [1:0] REG_EVT_FLOAT    = 2'd2;
  localparam logic [1:0] REG_EVT_STATUS   = 2'd3;

  // One classified input transaction as it sits in the front queue.
  typedef struct packed {
    logic       arm;
    logic       is_soh;
    logic       is_ack;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [14:0] command_word;
    logic [15:0] event_id;
    logic [31:0] status_word;
    logic [12:0] payload_count;
    logic [7:0]  control_byte;
    logic        send_ack;
  } res_t;

  // MSB-first CRC16 over one byte, eight shift steps.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ poly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/crcfr_front.sv =====
// ----------------------------------------------------------------------------
// crcfr_front
// Accepts input transactions, tags them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_front (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_push,
  output logic               in_full,
  input  wire                in_kind,
  input  wire  [7:0]         in_rx_byte,
  output logic               q_valid,
  output crcfr_pkg::item_t   q_item,
  input  wire                q_pop
);

  crcfr_pkg::item_t slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;
  crcfr_pkg::item_t new_item;

  assign in_full = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_item  = slot_r[rd_ptr_r];
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    new_item.arm    = in_kind;
    new_item.data   = in_rx_byte;
    new_item.is_soh = !in_kind && (in_rx_byte == crcfr_pkg::SOH_BYTE);
    new_item.is_ack = !in_kind && (in_rx_byte == crcfr_pkg::ACK_BYTE);
  end

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

// ===== design/crcfr_parser.sv =====
// ----------------------------------------------------------------------------
// crcfr_parser
// Frame parser: walks SOH, CTL, length, data and CRC, and builds results.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_parser #(
  parameter int MAX_FRAME = 4096
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_index,
  input  wire  [15:0]        cfg_data,
  input  wire                q_valid,
  input  crcfr_pkg::item_t   q_item,
  output logic               q_pop,
  input  wire                res_room,
  output logic               res_valid,
  output crcfr_pkg::res_t    res
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_CTL, PH_LEN_HI, PH_LEN_LO, PH_DATA, PH_CRC_HI, PH_CRC_LO
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        await_r, await_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic        evt_r, evt_nxt;
  logic [31:0] status_r, status_nxt;
  logic [7:0]  ctl_r, ctl_nxt;
  logic [12:0] pcnt_r, pcnt_nxt;

  logic [15:0] poly_r;
  logic [14:0] ev_entry_r, ev_float_r, ev_status_r;

  logic        advance;
  logic [7:0]  b;
  logic [15:0] crc_upd;
  logic [15:0] idx_inc;
  logic [16:0] len_len_lo;

  function automatic logic is_event(input logic [15:0] c, input logic [14:0] e0,
                                    input logic [14:0] e1, input logic [14:0] e2);
    return (c[14:0] == e0) || (c[14:0] == e1) || (c[14:0] == e2);
  endfunction

  assign advance    = q_valid && res_room;
  assign q_pop      = advance;
  assign b          = q_item.data;
  assign crc_upd    = crcfr_pkg::crc16_step(crc_r, b, poly_r);
  assign idx_inc    = idx_r + 16'd1;
  assign len_len_lo = {1'b0, len_r[15:8], b} + 17'd6;

  always_comb begin
    phase_nxt  = phase_r;
    await_nxt  = await_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    crc_hi_nxt = crc_hi_r;
    cmd_nxt    = cmd_r;
    evt_nxt    = evt_r;
    status_nxt = status_r;
    ctl_nxt    = ctl_r;
    pcnt_nxt   = pcnt_r;
    res_valid  = 1'b0;
    res        = '0;

    if (advance) begin
      if (q_item.arm) begin
        // A sent command only arms the ACK wait; any frame in progress goes on.
        await_nxt = 1'b1;
      end else begin
        case (phase_r)
          PH_HUNT: begin
            if (q_item.is_soh) begin
              phase_nxt  = PH_CTL;
              crc_nxt    = '0;
              idx_nxt    = '0;
              len_nxt    = '0;
              cmd_nxt    = '0;
              status_nxt = '0;
              pcnt_nxt   = '0;
              evt_nxt    = 1'b0;
            end else if (await_r && q_item.is_ack) begin
              await_nxt = 1'b0;
              res_valid = 1'b1;
              res.kind  = crcfr_pkg::KIND_ACK;
            end
          end
          PH_CTL: begin
            ctl_nxt   = b;
            crc_nxt   = crc_upd;
            phase_nxt = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            len_nxt   = {b, 8'h00};
            crc_nxt   = crc_upd;
            phase_nxt = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            len_nxt = {len_r[15:8], b};
            crc_nxt = crc_upd;
            if (len_len_lo > 17'(MAX_FRAME)) begin
              phase_nxt        = PH_HUNT;
              res_valid        = 1'b1;
              res.kind         = crcfr_pkg::KIND_LEN_ERR;
              res.control_byte = ctl_r;
            end else begin
              evt_nxt   = is_event(cmd_r, ev_entry_r, ev_float_r, ev_status_r);
              idx_nxt   = '0;
              phase_nxt = ({len_r[15:8], b} == 16'd0) ? PH_CRC_HI : PH_DATA;
            end
          end
          PH_DATA: begin
            crc_nxt = crc_upd;
            idx_nxt = idx_inc;
            if (idx_inc >= len_r) begin
              phase_nxt = PH_CRC_HI;
            end
            if (idx_r == 16'd0) begin
              cmd_nxt = {b, 8'h00};
              evt_nxt = is_event({b, 8'h00}, ev_entry_r, ev_float_r, ev_status_r);
            end else if (idx_r == 16'd1) begin
              cmd_nxt = {cmd_r[15:8], b};
              evt_nxt = is_event({cmd_r[15:8], b}, ev_entry_r, ev_float_r, ev_status_r);
            end else if (!evt_r && (idx_r < 16'd8)) begin
              // Response header: offsets 4 to 7 carry the big-endian status.
              if (idx_r >= 16'd4) begin
                status_nxt = {status_r[23:0], b};
              end
            end else begin
              pcnt_nxt          = pcnt_r + 13'd1;
              res_valid         = 1'b1;
              res.kind          = crcfr_pkg::KIND_PAYLOAD;
              res.payload_byte  = b;
              res.payload_count = pcnt_r + 13'd1;
            end
          end
          PH_CRC_HI: begin
            crc_hi_nxt = b;
            phase_nxt  = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            phase_nxt         = PH_HUNT;
            res_valid         = 1'b1;
            res.command_word  = cmd_r[14:0];
            res.payload_count = pcnt_r;
            res.control_byte  = ctl_r;
            if ({crc_hi_r, b} != crc_r) begin
              res.kind = crcfr_pkg::KIND_CRC_ERR;
            end else if (evt_r) begin
              res.kind     = crcfr_pkg::KIND_EVT_DONE;
              res.event_id = cmd_r;
              res.send_ack = 1'b1;
            end else begin
              res.kind        = crcfr_pkg::KIND_RESP_DONE;
              res.status_word = status_r;
              res.send_ack    = 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      await_r  <= 1'b0;
      idx_r    <= '0;
      len_r    <= '0;
      crc_r    <= '0;
      crc_hi_r <= '0;
      cmd_r    <= '0;
      evt_r    <= 1'b0;
      status_r <= '0;
      ctl_r    <= '0;
      pcnt_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      await_r  <= await_nxt;
      idx_r    <= idx_nxt;
      len_r    <= len_nxt;
      crc_r    <= crc_nxt;
      crc_hi_r <= crc_hi_nxt;
      cmd_r    <= cmd_nxt;
      evt_r    <= evt_nxt;
      status_r <= status_nxt;
      ctl_r    <= ctl_nxt;
      pcnt_r   <= pcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r      <= 16'h1021;
      ev_entry_r  <= '0;
      ev_float_r  <= '0;
      ev_status_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        crcfr_pkg::REG_CRC_POLY:   poly_r      <= cfg_data;
        crcfr_pkg::REG_EVT_ENTRY:  ev_entry_r  <= cfg_data[14:0];
        crcfr_pkg::REG_EVT_FLOAT:  ev_float_r  <= cfg_data[14:0];
        crcfr_pkg::REG_EVT_STATUS: ev_status_r <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/crcfr_out_q.sv =====
// ----------------------------------------------------------------------------
// crcfr_out_q
// Two-entry result queue that shows the oldest result to the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_out_q (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               wr_en,
  input  crcfr_pkg::res_t   wr_res,
  output logic              room,
  output logic              out_empty,
  input  wire               out_pop,
  output crcfr_pkg::res_t   rd_res
);

  crcfr_pkg::res_t slot_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            do_pop;

  assign out_empty = (count_r == 2'd0);
  assign do_pop    = out_pop && !out_empty;
  // A full queue still takes a result in the cycle its head leaves.
  assign room      = (count_r != 2'd2) || out_pop;
  assign rd_res    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, wr_en} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_res;
    end
  end

endmodule

`default_nettype wire

// ===== design/crc_framed_response_receiver.sv =====
// An input and its result are registered in the front and the result queue in turn.
// Throughput: one input transaction or byte per cycle while the result queue has room.
// The byte CRC update is a combinational eight-step unit inside the parser.
// Synchronous active-low reset empties both queues, restores the hunt state and
// loads the register reset values; the block accepts input in the next cycle.
// ----------------------------------------------------------------------------
// crc_framed_response_receiver
// Deframes SOH/CTL/length/data/CRC16 frames and reports ACKs and frame results.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_framed_response_receiver #(
  parameter int MAX_FRAME = 4096
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data,
  input  wire         in_push,
  output logic        in_full,
  input  wire         in_kind,
  input  wire  [7:0]  in_rx_byte,
  output logic        out_empty,
  input  wire         out_pop,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [14:0] out_command_word,
  output logic [15:0] out_event_id,
  output logic [31:0] out_status_word,
  output logic [12:0] out_payload_count,
  output logic [7:0]  out_control_byte,
  output logic        out_send_ack
);

  logic             q_valid;
  logic             q_pop;
  crcfr_pkg::item_t q_item;
  logic             res_room;
  logic             res_valid;
  crcfr_pkg::res_t  res;
  crcfr_pkg::res_t  head;

  crcfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_kind    (in_kind),
    .in_rx_byte (in_rx_byte),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  crcfr_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_room  (res_room),
    .res_valid (res_valid),
    .res       (res)
  );

  crcfr_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (res_valid),
    .wr_res    (res),
    .room      (res_room),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .rd_res    (head)
  );

  assign out_kind          = head.kind;
  assign out_payload_byte  = head.payload_byte;
  assign out_command_word  = head.command_word;
  assign out_event_id      = head.event_id;
  assign out_status_word   = head.status_word;
  assign out_payload_count = head.payload_count;
  assign out_control_byte  = head.control_byte;
  assign out_send_ack      = head.send_ack;

endmodule

`default_nettype wire

// ===== design/crcfr_checker.sv =====
// ----------------------------------------------------------------------------
// crcfr_checker
// Port-level assertions for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_full,
  input wire        out_empty,
  input wire        out_pop,
  input wire [2:0]  out_kind,
  input wire [7:0]  out_payload_byte,
  input wire [15:0] out_event_id,
  input wire        out_send_ack
);

  // After reset the result queue is empty and the input queue is not full.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // A waiting result that is not taken keeps its kind.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_kind)))
    else $error("stalled result changed");

  // Only payload transactions carry a data byte.
  a_payload_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_kind != crcfr_pkg::KIND_PAYLOAD)) |-> (out_payload_byte == 8'd0))
    else $error("data byte on a non-payload result");

  // An ACK request is raised only for frames whose CRC matched.
  a_send_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_send_ack) |->
      ((out_kind == crcfr_pkg::KIND_RESP_DONE) || (out_kind == crcfr_pkg::KIND_EVT_DONE)))
    else $error("ACK request on a bad frame");

  // The event id is reported for event frames alone.
  a_event_id: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_kind != crcfr_pkg::KIND_EVT_DONE)) |-> (out_event_id == 16'd0))
    else $error("event id on a non-event result");

endmodule

bind crc_framed_response_receiver crcfr_checker u_crcfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_kind         (out_kind),
  .out_payload_byte (out_payload_byte),
  .out_event_id     (out_event_id),
  .out_send_ack     (out_send_ack)
);

`default_nettype wire
